/* rtl/bmpq_pkg.sv */
// ---------------------------------------------------------------------------
// bmpq_pkg
// Shared types, sizes and helper functions of the bucket min priority queue.
// ---------------------------------------------------------------------------
package bmpq_pkg;

    // Value range and counter sizes.
    localparam int VALUE_SPAN     = 1024;
    localparam int VALUE_BITS     = $clog2(VALUE_SPAN);
    localparam int COUNT_BITS     = 16;
    localparam int TOTAL_BITS     = 16;

    // Occupancy bitmap: one bit per value, held as words in a small RAM,
    // with one summary bit per word held in flops.
    localparam int MAP_WORD_BITS  = 32;
    localparam int MAP_SEL_BITS   = $clog2(MAP_WORD_BITS);
    localparam int MAP_WORDS      = VALUE_SPAN / MAP_WORD_BITS;
    localparam int MAP_ADDR_BITS  = $clog2(MAP_WORDS);

    // Stream payload widths.
    localparam int IN_TDATA_BITS  = 16;
    localparam int OUT_TDATA_BITS = 16;
    localparam int OUT_TUSER_BITS = 2;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Request kinds.
    localparam logic ACT_ADD     = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED     = 2'd0,
        ST_REJECTED  = 2'd1,
        ST_EXTRACTED = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ADD_UPD,
        S_EX_FIND,
        S_EX_UPD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clr_step;
        logic rd_add;
        logic rd_scan_word;
        logic rd_scan_cnt;
        logic commit_add;
        logic commit_ext;
        logic emit_empty;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_extract;
        logic total_zero;
        logic slot_free;
    } t_dp_stat;

    // Index of the lowest set bit of a bitmap word (zero when none is set).
    function automatic logic [MAP_SEL_BITS-1:0] first_bit(input logic [MAP_WORD_BITS-1:0] w);
        logic [MAP_SEL_BITS-1:0] idx;
        idx = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = MAP_SEL_BITS'(i);
            end
        end
        return idx;
    endfunction

    // Index of the lowest set bit of the summary (zero when none is set).
    function automatic logic [MAP_ADDR_BITS-1:0] first_word(input logic [MAP_WORDS-1:0] s);
        logic [MAP_ADDR_BITS-1:0] idx;
        idx = '0;
        for (int i = MAP_WORDS - 1; i >= 0; i--) begin
            if (s[i]) begin
                idx = MAP_ADDR_BITS'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/bmpq_ram.sv */
// ---------------------------------------------------------------------------
// bmpq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that is captured only when the read is enabled.
// ---------------------------------------------------------------------------
module bmpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bmpq_ctrl.sv */
// ---------------------------------------------------------------------------
// bmpq_ctrl
// Controller of the priority queue: clearing pass, request decode and the
// read and update steps of adds and extracts.
// ---------------------------------------------------------------------------
module bmpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bmpq_pkg::t_dp_stat i_stat,
    output bmpq_pkg::t_dp_cmd  o_cmd
);
    import bmpq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_stat.is_extract) begin
                    n_state = S_ADD_UPD;
                end else if (!i_stat.total_zero) begin
                    n_state = S_EX_FIND;
                end else if (i_stat.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_ADD_UPD: begin
                if (i_stat.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EX_FIND: begin
                n_state = S_EX_UPD;
            end
            S_EX_UPD: begin
                if (i_stat.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.rd_add       = !i_stat.is_extract;
                o_cmd.rd_scan_word = i_stat.is_extract && !i_stat.total_zero;
                o_cmd.emit_empty   = i_stat.is_extract && i_stat.total_zero &&
                                     i_stat.slot_free;
            end
            S_ADD_UPD: begin
                o_cmd.commit_add = i_stat.slot_free;
            end
            S_EX_FIND: begin
                o_cmd.rd_scan_cnt = 1'b1;
            end
            S_EX_UPD: begin
                o_cmd.commit_ext = i_stat.slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/bmpq_dp.sv */
// ---------------------------------------------------------------------------
// bmpq_dp
// Datapath of the priority queue: counter RAM, occupancy bitmap, item total
// and the output register.
// ---------------------------------------------------------------------------
module bmpq_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bmpq_pkg::t_dp_cmd                   i_cmd,
    output bmpq_pkg::t_dp_stat                  o_stat,
    input  logic                                i_action,
    input  logic [bmpq_pkg::VALUE_BITS-1:0]     i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bmpq_pkg::t_status                   o_status,
    output logic [bmpq_pkg::VALUE_BITS-1:0]     o_min_value
);
    import bmpq_pkg::*;

    logic                     r_action;
    logic [VALUE_BITS-1:0]    r_value;
    logic [TOTAL_BITS-1:0]    r_total;
    logic [MAP_WORDS-1:0]     r_summary;
    logic [MAP_ADDR_BITS-1:0] r_word_idx;
    logic [VALUE_BITS-1:0]    r_clr_addr;
    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [VALUE_BITS-1:0]    r_out_min;

    logic                     cnt_we;
    logic [VALUE_BITS-1:0]    cnt_waddr;
    logic [COUNT_BITS-1:0]    cnt_wdata;
    logic                     cnt_re;
    logic [VALUE_BITS-1:0]    cnt_raddr;
    logic [COUNT_BITS-1:0]    cnt_rdata;
    logic                     map_we;
    logic [MAP_ADDR_BITS-1:0] map_waddr;
    logic [MAP_WORD_BITS-1:0] map_wdata;
    logic                     map_re;
    logic [MAP_ADDR_BITS-1:0] map_raddr;
    logic [MAP_WORD_BITS-1:0] map_rdata;

    logic                     slot_free;
    logic                     add_ok;
    logic [MAP_WORD_BITS-1:0] bit_mask;
    logic [COUNT_BITS-1:0]    cnt_dec;
    logic [MAP_WORD_BITS-1:0] word_dec;
    logic [MAP_ADDR_BITS-1:0] scan_word;
    logic [MAP_SEL_BITS-1:0]  scan_bit;
    logic                     load_out;

    assign slot_free = !r_out_valid || i_out_ready;
    assign bit_mask  = MAP_WORD_BITS'(1) << r_value[MAP_SEL_BITS-1:0];
    assign cnt_dec   = cnt_rdata - COUNT_BITS'(1);
    assign word_dec  = (cnt_dec == '0) ? (map_rdata & ~bit_mask) : map_rdata;
    assign scan_word = first_word(r_summary);
    assign scan_bit  = first_bit(map_rdata);

    // An add is refused when its value is out of range or a count would wrap.
    assign add_ok = ({1'b0, r_value} < (VALUE_BITS + 1)'(VALUE_SPAN)) &&
                    (r_total != TOTAL_MAX) && (cnt_rdata != COUNT_MAX);

    assign load_out = i_cmd.commit_add || i_cmd.commit_ext || i_cmd.emit_empty;

    // Read side: adds look up their own value, extracts walk summary, word
    // and counter in turn.
    always_comb begin
        cnt_re    = i_cmd.rd_add || i_cmd.rd_scan_cnt;
        map_re    = i_cmd.rd_add || i_cmd.rd_scan_word;
        cnt_raddr = i_cmd.rd_scan_cnt ? {r_word_idx, scan_bit} : r_value;
        map_raddr = i_cmd.rd_scan_word ? scan_word : r_value[VALUE_BITS-1:MAP_SEL_BITS];
    end

    // Write side: the clearing pass zeroes both memories, commits update them.
    always_comb begin
        cnt_we    = i_cmd.clr_step || (i_cmd.commit_add && add_ok) || i_cmd.commit_ext;
        map_we    = cnt_we;
        cnt_waddr = r_value;
        map_waddr = r_value[VALUE_BITS-1:MAP_SEL_BITS];
        cnt_wdata = '0;
        map_wdata = '0;
        priority if (i_cmd.clr_step) begin
            cnt_waddr = r_clr_addr;
            map_waddr = r_clr_addr[MAP_ADDR_BITS-1:0];
        end else if (i_cmd.commit_add) begin
            cnt_wdata = cnt_rdata + COUNT_BITS'(1);
            map_wdata = map_rdata | bit_mask;
        end else if (i_cmd.commit_ext) begin
            cnt_wdata = cnt_dec;
            map_wdata = word_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_summary   <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + VALUE_BITS'(1);
            end
            if (i_cmd.commit_add && add_ok) begin
                r_total <= r_total + TOTAL_BITS'(1);
                r_summary[r_value[VALUE_BITS-1:MAP_SEL_BITS]] <= 1'b1;
            end
            if (i_cmd.commit_ext) begin
                r_total <= r_total - TOTAL_BITS'(1);
                if (word_dec == '0) begin
                    r_summary[r_value[VALUE_BITS-1:MAP_SEL_BITS]] <= 1'b0;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
        if (i_cmd.rd_scan_word) begin
            r_word_idx <= scan_word;
        end
        // The found minimum replaces the request value, so both commits
        // write at the same address.
        if (i_cmd.rd_scan_cnt) begin
            r_value <= {r_word_idx, scan_bit};
        end
        if (i_cmd.commit_add) begin
            r_out_status <= add_ok ? ST_ADDED : ST_REJECTED;
            r_out_min    <= '0;
        end else if (i_cmd.commit_ext) begin
            r_out_status <= ST_EXTRACTED;
            r_out_min    <= r_value;
        end else if (i_cmd.emit_empty) begin
            r_out_status <= ST_EMPTY;
            r_out_min    <= '0;
        end
    end

    bmpq_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (VALUE_SPAN)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    bmpq_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    assign o_stat.clr_last   = (r_clr_addr == '1);
    assign o_stat.is_extract = (r_action == ACT_EXTRACT);
    assign o_stat.total_zero = (r_total == '0);
    assign o_stat.slot_free  = slot_free;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_min_value = r_out_min;

endmodule

/* rtl/bucket_min_priority_queue.sv */
// ---------------------------------------------------------------------------
// bucket_min_priority_queue
// Multiset of small integers with add and extract-min, kept as one counter
// per value plus a two-level occupancy bitmap that finds the minimum.
// ---------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tuser[0] action, tdata[9:0] value
//  m_axis    out        tuser[1:0] status, tdata[9:0] min_value
//
//  After reset the counter RAM and the bitmap RAM are cleared, one entry a
//  cycle, with s_axis_tready low.
//  An add reads its counter and bitmap word in decode and then updates them;
//  an extract reads the bitmap word in decode, then the counter, then
//  updates both; an extract on an empty queue answers from decode.
//  One request is in flight at a time. A result waits in the output register
//  while the next request is accepted; a request stalls in its last step
//  only while that register is still full.
// ---------------------------------------------------------------------------
module bucket_min_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] value, [15:10] zero
    input  logic [0:0]  s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] min_value, [15:10] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import bmpq_pkg::*;

    t_dp_cmd               cmd;
    t_dp_stat              stat;
    t_status               status;
    logic [VALUE_BITS-1:0] min_value;

    bmpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bmpq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_action    (s_axis_tuser[0]),
        .i_value     (s_axis_tdata[VALUE_BITS-1:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_min_value (min_value)
    );

    assign m_axis_tdata = OUT_TDATA_BITS'(min_value);
    assign m_axis_tuser = OUT_TUSER_BITS'(status);

endmodule

/* rtl/bmpq_chk.sv */
// ---------------------------------------------------------------------------
// bmpq_chk
// Port-level checks of the priority queue, bound to the top level.
// ---------------------------------------------------------------------------
module bmpq_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import bmpq_pkg::*;

    // Reset empties the output register.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Only one request is in flight: acceptance closes the input side.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request accepted while one is in flight");

    // A new result is produced by a request step, never straight from idle.
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a request in flight");

    // Only an extracted result carries a value.
    a_min_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_EXTRACTED) |-> (m_axis_tdata == '0))
        else $error("value returned with a non-extract status");

endmodule

bind bucket_min_priority_queue bmpq_chk u_bmpq_chk (.*);
